[design/assert_macros.svh]
// assertion helpers for the utf8 escape core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/utfv_pkg.sv]
package utfv_pkg;

    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    // one queued output run: up to four characters
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            err;
    } job_t;

endpackage

[design/utfv_front.sv]
module utfv_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,
    input  logic           s_tlast,
    input  logic           q_full,
    output logic           q_push,
    output utfv_pkg::job_t q_job
);
    import utfv_pkg::*;

    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_X      = 8'h78;

    logic [2:0]       seq_width_reg, seq_width_next;
    logic [1:0]       bytes_left_reg, bytes_left_next;
    logic [20:0]      code_point_reg, code_point_next;
    logic [2:0][7:0]  held_reg, held_next;
    logic             disc_reg, disc_next;

    function automatic logic [7:0] named_esc(input logic [20:0] c);
        logic [7:0] e;
        case (c)
            21'h5c:   e = 8'h5c;
            21'h00:   e = 8'h30;
            21'h08:   e = 8'h62;
            21'h0c:   e = 8'h66;
            21'h0a:   e = 8'h6e;
            21'h0d:   e = 8'h72;
            21'h09:   e = 8'h74;
            21'h07:   e = 8'h61;
            21'h0b:   e = 8'h76;
            21'h1b:   e = 8'h65;
            21'h85:   e = 8'h4e;
            21'ha0:   e = 8'h5f;
            21'h2028: e = 8'h4c;
            21'h2029: e = 8'h50;
            default:  e = 8'h00;
        endcase
        return e;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10)
        begin
            r = 8'h30 + {4'd0, v};
        end
        else
        begin
            r = 8'h57 + {4'd0, v};
        end
        return r;
    endfunction

    function automatic job_t make_point(input logic [20:0] c, input logic [2:0] w,
                                        input logic [7:0] cur,
                                        input logic [2:0][7:0] held);
        job_t       j;
        logic [7:0] e;
        e = named_esc(c);
        j.err = 1'b0;
        j.chars = '0;
        if (e != 8'h00)
        begin
            j.chars[0] = CH_BSLASH;
            j.chars[1] = e;
            j.last_idx = 2'd1;
        end
        else if ((c >= 21'h01 && c <= 21'h1f) || c == 21'h7f ||
                 (c >= 21'h80 && c <= 21'h9f))
        begin
            j.chars[0] = CH_BSLASH;
            j.chars[1] = CH_X;
            j.chars[2] = hex_char(c[7:4]);
            j.chars[3] = hex_char(c[3:0]);
            j.last_idx = 2'd3;
        end
        else
        begin
            case (w)
                3'd2:
                begin
                    j.chars[0] = held[0];
                    j.chars[1] = cur;
                end
                3'd3:
                begin
                    j.chars[0] = held[0];
                    j.chars[1] = held[1];
                    j.chars[2] = cur;
                end
                3'd4:
                begin
                    j.chars[0] = held[0];
                    j.chars[1] = held[1];
                    j.chars[2] = held[2];
                    j.chars[3] = cur;
                end
                default:
                begin
                    j.chars[0] = cur;
                end
            endcase
            j.last_idx = 2'(w - 3'd1);
        end
        return j;
    endfunction

    logic        acc;
    logic [2:0]  lead_w;
    logic [20:0] cp_cont;
    logic [2:0]  idx;
    logic [1:0]  bl_dec;
    logic        bad_point;
    job_t        err_job;

    assign s_tready = !q_full;
    assign acc      = s_tvalid && s_tready;

    always_comb
    begin
        if (s_tdata[7] == 1'b0)
        begin
            lead_w = 3'd1;
        end
        else if (s_tdata[7:5] == 3'b110)
        begin
            lead_w = 3'd2;
        end
        else if (s_tdata[7:4] == 4'b1110)
        begin
            lead_w = 3'd3;
        end
        else if (s_tdata[7:3] == 5'b11110)
        begin
            lead_w = 3'd4;
        end
        else
        begin
            lead_w = 3'd0;
        end
    end

    assign cp_cont = {code_point_reg[14:0], s_tdata[5:0]};
    assign idx     = seq_width_reg - {1'b0, bytes_left_reg};
    assign bl_dec  = bytes_left_reg - 2'd1;
    assign bad_point = (seq_width_reg == 3'd4 && cp_cont < 21'h10000) ||
                       (seq_width_reg == 3'd3 && cp_cont < 21'h800) ||
                       (seq_width_reg == 3'd2 && cp_cont < 21'h80) ||
                       (cp_cont >= 21'hd800 && cp_cont <= 21'hdfff) ||
                       (cp_cont >= 21'h110000);

    always_comb
    begin
        err_job          = '0;
        err_job.err      = 1'b1;
        err_job.last_idx = 2'd0;
    end

    always_comb
    begin
        seq_width_next  = seq_width_reg;
        bytes_left_next = bytes_left_reg;
        code_point_next = code_point_reg;
        held_next       = held_reg;
        disc_next       = disc_reg;
        q_push          = 1'b0;
        q_job           = err_job;
        if (acc)
        begin
            if (disc_reg)
            begin
                if (s_tlast)
                begin
                    disc_next       = 1'b0;
                    seq_width_next  = 3'd0;
                    bytes_left_next = 2'd0;
                    code_point_next = '0;
                end
            end
            else if (bytes_left_reg == 2'd0)
            begin
                if (lead_w == 3'd0)
                begin
                    q_push    = 1'b1;
                    disc_next = !s_tlast;
                    seq_width_next  = 3'd0;
                    code_point_next = '0;
                end
                else if (lead_w == 3'd1)
                begin
                    q_push = 1'b1;
                    q_job  = make_point({13'd0, s_tdata}, 3'd1, s_tdata, held_reg);
                    seq_width_next  = 3'd0;
                    code_point_next = '0;
                end
                else
                begin
                    held_next[0] = s_tdata;
                    if (s_tlast)
                    begin
                        q_push          = 1'b1;
                        seq_width_next  = 3'd0;
                        code_point_next = '0;
                    end
                    else
                    begin
                        seq_width_next  = lead_w;
                        bytes_left_next = 2'(lead_w - 3'd1);
                        code_point_next = {13'd0, s_tdata & (8'hff >> lead_w)};
                    end
                end
            end
            else if (s_tdata[7:6] != 2'b10)
            begin
                q_push          = 1'b1;
                disc_next       = !s_tlast;
                seq_width_next  = 3'd0;
                bytes_left_next = 2'd0;
                code_point_next = '0;
            end
            else
            begin
                if (idx < 3'd3)
                begin
                    held_next[idx[1:0]] = s_tdata;
                end
                if (bl_dec != 2'd0)
                begin
                    if (s_tlast)
                    begin
                        q_push          = 1'b1;
                        seq_width_next  = 3'd0;
                        bytes_left_next = 2'd0;
                        code_point_next = '0;
                    end
                    else
                    begin
                        bytes_left_next = bl_dec;
                        code_point_next = cp_cont;
                    end
                end
                else
                begin
                    q_push          = 1'b1;
                    seq_width_next  = 3'd0;
                    bytes_left_next = 2'd0;
                    code_point_next = '0;
                    if (bad_point)
                    begin
                        disc_next = !s_tlast;
                    end
                    else
                    begin
                        q_job = make_point(cp_cont, seq_width_reg, s_tdata, held_reg);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_width_reg  <= '0;
            bytes_left_reg <= '0;
            code_point_reg <= '0;
            disc_reg       <= 1'b0;
        end
        else
        begin
            seq_width_reg  <= seq_width_next;
            bytes_left_reg <= bytes_left_next;
            code_point_reg <= code_point_next;
            disc_reg       <= disc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

[design/utfv_queue.sv]
module utfv_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  utfv_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           avail,
    output utfv_pkg::job_t pop_job
);
    import utfv_pkg::*;

    job_t           q_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign full    = (cnt_reg == (QAW + 1)'(QDEPTH));
    assign avail   = (cnt_reg != '0);
    assign pop_job = q_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && avail;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[design/utfv_back.sv]
module utfv_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_avail,
    input  utfv_pkg::job_t q_job,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast,
    output logic           m_tuser
);
    import utfv_pkg::*;

    job_t       job_reg;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic       take, done, load;

    assign m_tvalid = busy_reg;
    assign m_tdata  = job_reg.chars[idx_reg];
    assign m_tuser  = job_reg.err;
    assign m_tlast  = (idx_reg == job_reg.last_idx);

    assign take  = busy_reg && m_tready;
    assign done  = take && m_tlast;
    assign load  = q_avail && (!busy_reg || done);
    assign q_pop = load;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (done)
        begin
            busy_next = 1'b0;
            idx_next  = '0;
        end
        else if (take)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= q_job;
        end
    end

endmodule

[design/utf8_validate_escape_core.sv]
// path: the first result of a byte that completes a code point or an error is held in
//   a queue entry and then in the back-end job register before it can transfer
// throughput: one input byte per cycle while s_tready is high, one result per cycle while m_tready
//   is high; an escape of two or four results holds the back end and the two-entry queue back-pressures
// reset: rst_n (async, active low) drops any open sequence and discard state,
//   empties the queue and clears m_tvalid
module utf8_validate_escape_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // byte_in[7:0]
    input  logic       s_tlast,   // end_of_string
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // char_out[7:0]
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // bad_input
);
    import utfv_pkg::*;

    logic q_full, q_push, q_pop, q_avail;
    job_t push_job, pop_job;

    utfv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    utfv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .avail    (q_avail),
        .pop_job  (pop_job)
    );

    utfv_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_avail  (q_avail),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

[design/utfv_checker.sv]
`include "assert_macros.svh"

module utfv_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
    `ASSERT_SAME(a_err_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata == 8'h00 && m_tlast)
    `ASSERT_NEXT(a_run_cont, clk, rst_n, m_tvalid && m_tready && !m_tlast, m_tvalid && !m_tuser)
    `ASSERT_NEXT(a_hex_next, clk, rst_n, m_tvalid && m_tready && !m_tlast && m_tdata == 8'h78, m_tvalid && !m_tuser && !m_tlast)
    `ASSERT_NEXT(a_in_hold, clk, rst_n, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata) && $stable(s_tlast))

endmodule

bind utf8_validate_escape_core utfv_checker u_chk (.*);

[verif/utf8_validate_escape_core_test.sv]
module utf8_validate_escape_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIRECTED_ITEMS = 24;
    localparam int RANDOM_ITEMS   = 460;
    localparam int QUIET_TAIL     = 60;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 16;

    localparam logic [7:0] BACKSLASH  = 8'h5c;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_A    = 8'h61;

    typedef struct packed {
        logic [7:0] ch;
        logic       bad;
        logic       run_last;
    } esc_char_t;

    typedef enum int {
        FAULT_STRAY_LEAD,
        FAULT_BAD_CONT,
        FAULT_OVERLONG,
        FAULT_SURROGATE,
        FAULT_TOO_BIG,
        FAULT_CUT_SHORT
    } fault_kind_t;

    class escape_checker;
        esc_char_t   expected_chars[$];
        int unsigned mismatches;
        logic [2:0]  seq_width;
        logic [1:0]  bytes_left;
        logic [20:0] code_point;
        logic [7:0]  held[3];
        bit          discarding;

        function new();
            mismatches = 0;
            seq_width  = 0;
            bytes_left = 0;
            code_point = 0;
            held[0]    = 0;
            held[1]    = 0;
            held[2]    = 0;
            discarding = 0;
        endfunction

        function int pending_count();
            return expected_chars.size();
        endfunction

        function void clear_seq();
            seq_width  = 0;
            bytes_left = 0;
            code_point = 0;
        endfunction

        function void push_error(logic last);
            esc_char_t err;
            err = '{8'h00, 1'b1, 1'b1};
            expected_chars.push_back(err);
            clear_seq();
            discarding = !last;
        endfunction

        function logic [7:0] hex_char(logic [3:0] v);
            return (v < 10) ? ASCII_ZERO + v : ASCII_A + v - 8'd10;
        endfunction

        function logic [7:0] named_char(logic [20:0] c);
            case (c)
                21'h00005c: return "\\";
                21'h000000: return "0";
                21'h000008: return "b";
                21'h00000c: return "f";
                21'h00000a: return "n";
                21'h00000d: return "r";
                21'h000009: return "t";
                21'h000007: return "a";
                21'h00000b: return "v";
                21'h00001b: return "e";
                21'h000085: return "N";
                21'h0000a0: return "_";
                21'h002028: return "L";
                21'h002029: return "P";
                default:    return 8'h00;
            endcase
        endfunction

        function void push_point(logic [20:0] c, int w, logic [7:0] cur);
            logic [7:0] chars[4];
            logic [7:0] e;
            esc_char_t  item;
            int         n;
            int         i;
            e = named_char(c);
            n = 0;
            if (e != 8'h00)
            begin
                chars[0] = BACKSLASH;
                chars[1] = e;
                n = 2;
            end
            else if ((c >= 21'h01 && c <= 21'h1f) || c == 21'h7f ||
                     (c >= 21'h80 && c <= 21'h9f))
            begin
                chars[0] = BACKSLASH;
                chars[1] = "x";
                chars[2] = hex_char(c[7:4]);
                chars[3] = hex_char(c[3:0]);
                n = 4;
            end
            else
            begin
                for (i = 0; i + 1 < w && i < 3; i++)
                begin
                    chars[n] = held[i];
                    n = n + 1;
                end
                chars[n] = cur;
                n = n + 1;
            end
            for (i = 0; i < n; i++)
            begin
                item = '{chars[i], 1'b0, (i == n - 1)};
                expected_chars.push_back(item);
            end
        endfunction

        // predicts the characters caused by one accepted input byte
        function void note_input(logic [7:0] b, logic last);
            logic [2:0]  w;
            logic [20:0] c;
            int          idx;
            if (discarding)
            begin
                if (last)
                begin
                    discarding = 0;
                    clear_seq();
                end
                return;
            end
            if (bytes_left == 0)
            begin
                if (b[7] == 1'b0)
                    w = 1;
                else if (b[7:5] == 3'b110)
                    w = 2;
                else if (b[7:4] == 4'b1110)
                    w = 3;
                else if (b[7:3] == 5'b11110)
                    w = 4;
                else
                    w = 0;
                if (w == 0)
                begin
                    push_error(last);
                    return;
                end
                if (w == 1)
                begin
                    clear_seq();
                    push_point({13'd0, b}, 1, b);
                    return;
                end
                seq_width  = w;
                bytes_left = w - 1;
                code_point = {13'd0, b & (8'hff >> w)};
                held[0]    = b;
                if (last)
                    push_error(last);
                return;
            end
            if (b[7:6] != 2'b10)
            begin
                push_error(last);
                return;
            end
            code_point = {code_point[14:0], b[5:0]};
            idx = seq_width - bytes_left;
            if (idx < 3)
                held[idx] = b;
            bytes_left = bytes_left - 1;
            if (bytes_left != 0)
            begin
                if (last)
                    push_error(last);
                return;
            end
            w = seq_width;
            c = code_point;
            if ((w == 4 && c < 21'h10000) || (w == 3 && c < 21'h800) ||
                (w == 2 && c < 21'h80) || (c >= 21'hd800 && c <= 21'hdfff) ||
                c >= 21'h110000)
            begin
                push_error(last);
                return;
            end
            clear_seq();
            push_point(c, w, b);
        endfunction

        function void check_result(logic [7:0] ch, logic bad, logic lst);
            esc_char_t want;
            if (expected_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: char %h bad %b last %b", ch, bad, lst);
                return;
            end
            want = expected_chars.pop_front();
            if (want.ch !== ch || want.bad !== bad || want.run_last !== lst)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected char %h bad %b last %b, got char %h bad %b last %b",
                             want.ch, want.bad, want.run_last, ch, bad, lst);
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    escape_checker board = new();
    logic [7:0]    str_q[$];
    int            bytes_sent = 0;
    bit            tx_idle_on = 1'b1;
    bit            rx_idle_on = 1'b1;
    bit            hold_req = 1'b0;

    utf8_validate_escape_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // byte_in[7:0]
        .s_tlast  (s_tlast),   // end_of_string
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // char_out[7:0]
        .m_tlast  (m_tlast),   // run_last
        .m_tuser  (m_tuser)    // bad_input
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            board.note_input(s_tdata, s_tlast);
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser, m_tlast);
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int width_of(int unsigned cp);
        if (cp < 'h80)
            return 1;
        if (cp < 'h800)
            return 2;
        if (cp < 'h10000)
            return 3;
        return 4;
    endfunction

    function automatic int unsigned valid_point(int w);
        int unsigned cp;
        case (w)
            1:       cp = $urandom_range(0, 'h7f);
            2:       cp = $urandom_range('h80, 'h7ff);
            3:
            begin
                cp = $urandom_range('h800, 'hffff);
                if (cp >= 'hd800 && cp <= 'hdfff)
                    cp = cp - 'h800;
            end
            default: cp = $urandom_range('h10000, 'h10ffff);
        endcase
        return cp;
    endfunction

    function automatic int unsigned named_point();
        case ($urandom_range(0, 13))
            0:       return 'h5c;
            1:       return 'h00;
            2:       return 'h08;
            3:       return 'h0c;
            4:       return 'h0a;
            5:       return 'h0d;
            6:       return 'h09;
            7:       return 'h07;
            8:       return 'h0b;
            9:       return 'h1b;
            10:      return 'h85;
            11:      return 'ha0;
            12:      return 'h2028;
            default: return 'h2029;
        endcase
    endfunction

    function automatic int unsigned pick_point();
        case ($urandom_range(0, 7))
            0, 1:    return valid_point($urandom_range(1, 4));
            2:       return named_point();
            3:       return $urandom_range(0, 'h1f);
            4:       return ($urandom_range(0, 3) == 0) ? 'h7f : $urandom_range('h80, 'h9f);
            5:       return $urandom_range('h20, 'h7e);
            6:       return $urandom_range('ha0, 'hff);
            default: return valid_point(4);
        endcase
    endfunction

    function automatic void put_point(input int unsigned cp, input int w);
        logic [20:0] c;
        c = cp;
        case (w)
            1:
                str_q.push_back({1'b0, c[6:0]});
            2:
            begin
                str_q.push_back({3'b110, c[10:6]});
                str_q.push_back({2'b10, c[5:0]});
            end
            3:
            begin
                str_q.push_back({4'b1110, c[15:12]});
                str_q.push_back({2'b10, c[11:6]});
                str_q.push_back({2'b10, c[5:0]});
            end
            default:
            begin
                str_q.push_back({5'b11110, c[20:18]});
                str_q.push_back({2'b10, c[17:12]});
                str_q.push_back({2'b10, c[11:6]});
                str_q.push_back({2'b10, c[5:0]});
            end
        endcase
    endfunction

    // returns 1 when the fault ends the string
    function automatic bit put_fault();
        fault_kind_t kind;
        logic [7:0]  b;
        int          w;
        int          start;
        int          drop;
        kind = fault_kind_t'($urandom_range(0, 5));
        w = $urandom_range(2, 4);
        case (kind)
            FAULT_STRAY_LEAD:
                str_q.push_back(($urandom_range(0, 1) == 0) ? 8'h80 + $urandom_range(0, 63)
                                                            : 8'hf8 + $urandom_range(0, 7));
            FAULT_BAD_CONT:
            begin
                start = str_q.size();
                put_point(valid_point(w), w);
                b = $urandom_range(0, 255);
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
                str_q[start + $urandom_range(1, w - 1)] = b;
            end
            FAULT_OVERLONG:
                put_point($urandom_range(0, (w == 2) ? 'h7f : (w == 3) ? 'h7ff : 'hffff), w);
            FAULT_SURROGATE:
                put_point($urandom_range('hd800, 'hdfff), 3);
            FAULT_TOO_BIG:
                put_point($urandom_range('h110000, 'h1fffff), 4);
            default:
            begin
                put_point(valid_point(w), w);
                drop = $urandom_range(1, w - 1);
                repeat (drop) void'(str_q.pop_back());
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    task automatic build_random_string();
        int          n;
        int          at;
        bit          faulty;
        int unsigned cp;
        str_q.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 6)) str_q.push_back($urandom_range(0, 255));
            return;
        end
        n = $urandom_range(1, 6);
        faulty = ($urandom_range(0, 4) == 0);
        at = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++)
        begin
            if (faulty && i == at)
            begin
                if (put_fault())
                    break;
            end
            else
            begin
                cp = pick_point();
                put_point(cp, width_of(cp));
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_string();
        for (int i = 0; i < str_q.size(); i++)
            send_byte(str_q[i], i == str_q.size() - 1);
    endtask

    initial
    begin
        bit hold_done;
        bit pause_done;
        hold_done = 1'b0;
        pause_done = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // named, hex and pass-through forms, then each kind of malformed string
        str_q = {8'h00, 8'h7f, 8'hc2, 8'h85, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
        send_string();
        str_q = {8'h80};
        send_string();
        str_q = {8'hff, 8'h41};
        send_string();
        str_q = {8'hc2, 8'h41};
        send_string();
        str_q = {8'hc0, 8'h80};
        send_string();
        str_q = {8'hed, 8'ha0, 8'h80};
        send_string();
        str_q = {8'hf4, 8'h90, 8'h80, 8'h80};
        send_string();
        str_q = {8'he2, 8'h80};
        send_string();

        while (bytes_sent < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            if (bytes_sent >= DIRECTED_ITEMS + RANDOM_ITEMS - QUIET_TAIL)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            else
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            if (!hold_done && bytes_sent >= 150)
            begin
                hold_done = 1'b1;
                hold_req = 1'b1;
                tx_idle_on = 1'b0;
            end
            if (!pause_done && bytes_sent >= 300)
            begin
                pause_done = 1'b1;
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (board.pending_count() != 0) @(posedge clk);
            end
            build_random_string();
            send_string();
        end

        s_tvalid <= 1'b0;
        while (board.pending_count() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending_count() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
